/* rtl/multi_queue_circular_fifo_unit_assert.svh */
// Assertion helpers for the multi-queue FIFO unit.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef MULTI_QUEUE_CIRCULAR_FIFO_UNIT_ASSERT_SVH
`define MULTI_QUEUE_CIRCULAR_FIFO_UNIT_ASSERT_SVH

// cond must hold at every clock edge
`define MQF_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// when ante holds, cons must hold in the same cycle
`define MQF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/mqf_pkg.sv */
`default_nettype none

package mqf_pkg;

    localparam int DATA_W  = 8;
    localparam int QID_W   = 2;
    localparam int OP_W    = 2;
    localparam int LEVEL_W = 5;

    localparam int DEF_QUEUE_COUNT = 4;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int OUT_FIFO_DEPTH = 4;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [QID_W-1:0]  queue_id;
        logic [DATA_W-1:0] write_data;
    } t_in_beat;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               accepted;
        logic               is_full;
        logic               is_empty;
        logic [LEVEL_W-1:0] fill_level;
    } t_out_beat;

    typedef struct packed {
        logic               accepted;
        logic               is_full;
        logic               is_empty;
        logic [LEVEL_W-1:0] fill_level;
    } t_status;

    typedef struct packed {
        logic    mem_wr;
        logic    mem_rd;
        t_status status;
    } t_cmd_ctl;

endpackage

`default_nettype wire

/* rtl/multi_queue_circular_fifo_unit.sv */
// Multi-queue circular FIFO unit.
// Input channel: present a beat on i_item and raise push; it is taken at a
// clock edge with push high and full low. A beat names an opcode (push, pop,
// clear, query) and a queue. Every beat yields exactly one result beat.
// Result channel: while empty is low, o_result holds the oldest result; it is
// taken at an edge with pop high. Results come out in input order.
// Path: command queue, back-end stage register, then result queue.
// Throughput: one beat per cycle unless the result queue backs up, set by the
// single address that the back end drives to the shared entry memory once per beat.
// Queue status (pointers, full flags) is resolved in the front end at the
// accept edge; memory access happens later in the back end, decoupled by a
// two-entry command queue. A four-entry result queue absorbs a stalled
// receiver; once it and the command queue fill, full goes high and input
// stalls with no beat lost.
// Reset (synchronous, active low) empties every queue and both internal
// queues; stored data bytes are not cleared.
`default_nettype none

`include "multi_queue_circular_fifo_unit_assert.svh"

module multi_queue_circular_fifo_unit import mqf_pkg::*; #(
    parameter int QUEUE_COUNT = DEF_QUEUE_COUNT,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    localparam int AW  = $clog2(QUEUE_COUNT * QUEUE_DEPTH),
    localparam int OCW = $clog2(OUT_FIFO_DEPTH + 1),
    localparam int CMD_W = $bits(t_cmd_ctl) + AW + DATA_W
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_beat  i_item,
    output logic           empty,
    input  wire logic      pop,
    output t_out_beat      o_result
);

    logic              accept;
    t_cmd_ctl          front_ctl;
    logic [AW-1:0]     front_addr;
    logic [DATA_W-1:0] front_wdata;
    logic [CMD_W-1:0]  cmd_rdata;
    logic              cmd_empty;
    logic              cmd_pop;
    t_cmd_ctl          cmd_ctl;
    logic [AW-1:0]     cmd_addr;
    logic [DATA_W-1:0] cmd_wdata;
    logic [OCW-1:0]    out_count;
    logic              out_push;
    logic              out_full;
    t_out_beat         out_beat;

    assign accept = push && !full;

    mqf_front #(
        .QUEUE_COUNT (QUEUE_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_beat  (i_item),
        .o_ctl   (front_ctl),
        .o_addr  (front_addr),
        .o_wdata (front_wdata)
    );

    mqf_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_wdata ({front_ctl, front_addr, front_wdata}),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_rdata),
        .o_empty (cmd_empty),
        .o_count ()
    );

    assign {cmd_ctl, cmd_addr, cmd_wdata} = cmd_rdata;

    mqf_back #(
        .QUEUE_COUNT (QUEUE_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd_ctl   (cmd_ctl),
        .i_cmd_addr  (cmd_addr),
        .i_cmd_wdata (cmd_wdata),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_beat  (out_beat)
    );

    mqf_fifo #(
        .WIDTH ($bits(t_out_beat)),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_beat),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_empty (empty),
        .o_count (out_count)
    );

    `MQF_ASSERT_IMPLIES(a_out_no_overflow, out_push, !out_full, "result beat dropped: queue full")
    `MQF_ASSERT_IMPLIES(a_empty_matches_level, out_push, out_beat.is_empty == (out_beat.fill_level == '0), "is_empty disagrees with fill_level")
    `MQF_ASSERT_IMPLIES(a_full_level, out_push && out_beat.is_full, out_beat.fill_level == LEVEL_W'(QUEUE_DEPTH), "full queue with wrong level")
    `MQF_ASSERT_HOLDS(a_cmd_pop_valid, !cmd_pop || !cmd_empty, "back end issued from empty command queue")

endmodule

`default_nettype wire

/* rtl/mqf_ram.sv */
`default_nettype none

module mqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/mqf_fifo.sv */
`default_nettype none

module mqf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty,
    output logic      [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

/* rtl/mqf_front.sv */
`default_nettype none

module mqf_front import mqf_pkg::*; #(
    parameter int QUEUE_COUNT = DEF_QUEUE_COUNT,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    localparam int PW = $clog2(QUEUE_DEPTH),
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1,
    localparam int AW = $clog2(QUEUE_COUNT * QUEUE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_in_beat          i_beat,
    output t_cmd_ctl               o_ctl,
    output logic      [AW-1:0]     o_addr,
    output logic      [DATA_W-1:0] o_wdata
);

    logic [PW-1:0]          r_wp [QUEUE_COUNT];
    logic [PW-1:0]          r_rp [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] r_full;

    logic               in_range;
    logic [QW-1:0]      q;
    logic [PW-1:0]      wp;
    logic [PW-1:0]      rp;
    logic               fl;
    logic [PW-1:0]      n_wp;
    logic [PW-1:0]      n_rp;
    logic               n_full;
    logic               ok;
    logic [PW-1:0]      ptr_sel;
    logic [LEVEL_W-1:0] lvl;

    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign in_range = (int'(i_beat.queue_id) < QUEUE_COUNT);
    assign q        = QW'(i_beat.queue_id);
    assign wp       = r_wp[q];
    assign rp       = r_rp[q];
    assign fl       = r_full[q];

    always_comb begin
        n_wp   = wp;
        n_rp   = rp;
        n_full = fl;
        ok     = 1'b0;
        unique case (i_beat.opcode)
            OP_PUSH: begin
                if (!fl) begin
                    n_wp   = f_adv(wp);
                    n_full = (f_adv(wp) == rp);
                    ok     = 1'b1;
                end
            end
            OP_POP: begin
                if (fl || wp != rp) begin
                    n_rp   = f_adv(rp);
                    n_full = 1'b0;
                    ok     = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_wp   = '0;
                n_rp   = '0;
                n_full = 1'b0;
            end
            OP_QUERY: begin
            end
        endcase
    end

    assign lvl = n_full ? LEVEL_W'(QUEUE_DEPTH)
                        : (LEVEL_W'(n_wp) - LEVEL_W'(n_rp)
                           + ((n_wp < n_rp) ? LEVEL_W'(QUEUE_DEPTH) : '0));

    always_comb begin
        if (in_range) begin
            o_ctl.mem_wr              = ok && (i_beat.opcode == OP_PUSH);
            o_ctl.mem_rd              = ok && (i_beat.opcode == OP_POP);
            o_ctl.status.accepted     = ok;
            o_ctl.status.is_full      = n_full;
            o_ctl.status.is_empty     = (lvl == '0);
            o_ctl.status.fill_level   = lvl;
        end else begin
            o_ctl.mem_wr              = 1'b0;
            o_ctl.mem_rd              = 1'b0;
            o_ctl.status.accepted     = 1'b0;
            o_ctl.status.is_full      = 1'b0;
            o_ctl.status.is_empty     = 1'b1;
            o_ctl.status.fill_level   = '0;
        end
    end

    assign ptr_sel = (i_beat.opcode == OP_PUSH) ? wp : rp;
    assign o_addr  = AW'(int'(q) * QUEUE_DEPTH + int'(ptr_sel));
    assign o_wdata = i_beat.write_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
            end
            r_full <= '0;
        end else if (i_valid && in_range) begin
            r_wp[q]   <= n_wp;
            r_rp[q]   <= n_rp;
            r_full[q] <= n_full;
        end
    end

endmodule

`default_nettype wire

/* rtl/mqf_back.sv */
`default_nettype none

module mqf_back import mqf_pkg::*; #(
    parameter int QUEUE_COUNT = DEF_QUEUE_COUNT,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    localparam int AW  = $clog2(QUEUE_COUNT * QUEUE_DEPTH),
    localparam int OCW = $clog2(OUT_FIFO_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire t_cmd_ctl          i_cmd_ctl,
    input  wire logic [AW-1:0]     i_cmd_addr,
    input  wire logic [DATA_W-1:0] i_cmd_wdata,
    output logic                   o_cmd_pop,
    input  wire logic [OCW-1:0]    i_out_count,
    output logic                   o_out_push,
    output t_out_beat              o_out_beat
);

    logic              issue;
    logic              r_s1_valid;
    t_cmd_ctl          r_s1_ctl;
    logic [DATA_W-1:0] ram_rdata;

    // issue only with room reserved in the result queue for the beat in flight
    assign issue = i_cmd_valid
                && ((int'(i_out_count) + int'(r_s1_valid)) < OUT_FIFO_DEPTH);
    assign o_cmd_pop = issue;

    mqf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (QUEUE_COUNT * QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (issue && i_cmd_ctl.mem_wr),
        .i_waddr (i_cmd_addr),
        .i_wdata (i_cmd_wdata),
        .i_raddr (i_cmd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_ctl <= i_cmd_ctl;
        end
    end

    assign o_out_push            = r_s1_valid;
    assign o_out_beat.read_data  = r_s1_ctl.mem_rd ? ram_rdata : '0;
    assign o_out_beat.accepted   = r_s1_ctl.status.accepted;
    assign o_out_beat.is_full    = r_s1_ctl.status.is_full;
    assign o_out_beat.is_empty   = r_s1_ctl.status.is_empty;
    assign o_out_beat.fill_level = r_s1_ctl.status.fill_level;

endmodule

`default_nettype wire

/* sim/multi_queue_circular_fifo_unit_tb.sv */
`default_nettype none

module multi_queue_circular_fifo_unit_tb;
    import mqf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QCOUNT     = DEF_QUEUE_COUNT;
    localparam int QDEPTH     = DEF_QUEUE_DEPTH;
    localparam int RAND_ITEMS = 1250;
    localparam int CALM_TAIL  = 150;
    localparam int REPORT_MAX = 10;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_beat  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_beat o_result;

    // predicted per-queue state
    logic [DATA_W-1:0] q_store [QCOUNT*QDEPTH];
    int                wr_ptr  [QCOUNT];
    int                rd_ptr  [QCOUNT];
    bit                q_full  [QCOUNT];

    t_in_beat  cmd_backlog [$];
    t_out_beat status_due  [$];
    int        beats_taken    = 0;
    int        beats_sent     = 0;
    int        mismatch_count = 0;
    int        send_gap       = 0;
    int        pop_gap        = 0;

    multi_queue_circular_fifo_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_beat apply_queue_op(t_in_beat b);
        t_out_beat r;
        int        q;
        int        lvl;
        r = '0;
        q = b.queue_id;
        case (b.opcode)
            OP_PUSH: begin
                if (!q_full[q]) begin
                    q_store[q*QDEPTH + wr_ptr[q]] = b.write_data;
                    wr_ptr[q] = (wr_ptr[q] + 1) % QDEPTH;
                    q_full[q] = (wr_ptr[q] == rd_ptr[q]);
                    r.accepted = 1'b1;
                end
            end
            OP_POP: begin
                if (q_full[q] || wr_ptr[q] != rd_ptr[q]) begin
                    r.read_data = q_store[q*QDEPTH + rd_ptr[q]];
                    rd_ptr[q] = (rd_ptr[q] + 1) % QDEPTH;
                    q_full[q] = 1'b0;
                    r.accepted = 1'b1;
                end
            end
            OP_CLEAR: begin
                wr_ptr[q] = 0;
                rd_ptr[q] = 0;
                q_full[q] = 1'b0;
            end
            default: ;
        endcase
        lvl = q_full[q] ? QDEPTH : (wr_ptr[q] - rd_ptr[q] + QDEPTH) % QDEPTH;
        r.is_full    = q_full[q];
        r.is_empty   = (lvl == 0);
        r.fill_level = lvl[LEVEL_W-1:0];
        return r;
    endfunction

    task automatic add_cmd(logic [OP_W-1:0] op, int q, int data);
        t_in_beat b;
        b.opcode     = op;
        b.queue_id   = q[QID_W-1:0];
        b.write_data = data[DATA_W-1:0];
        cmd_backlog.push_back(b);
    endtask

    task automatic add_mixed(int q);
        int r;
        int qq;
        r  = $urandom_range(0, 99);
        qq = ($urandom_range(0, 4) == 0) ? $urandom_range(0, QCOUNT-1) : q;
        if (r < 40)
            add_cmd(OP_PUSH, qq, $urandom_range(0, 255));
        else if (r < 80)
            add_cmd(OP_POP, qq, $urandom_range(0, 255));
        else if (r < 88)
            add_cmd(OP_CLEAR, qq, $urandom_range(0, 255));
        else
            add_cmd(OP_QUERY, qq, $urandom_range(0, 255));
    endtask

    // input side
    always @(negedge i_clk) begin
        if (beats_taken != beats_sent) begin
            void'(cmd_backlog.pop_front());
            beats_sent++;
        end
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
        end else if (cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 3);
            push <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
            push   <= 1'b1;
            i_item <= cmd_backlog[0];
        end else begin
            push <= 1'b0;
        end
    end

    // result side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end else if (cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
            pop_gap = $urandom_range(0, 3);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (status_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected result beat %p", $realtime, o_result);
                end else begin
                    want = status_due.pop_front();
                    if (o_result.read_data  !== want.read_data  ||
                        o_result.accepted   !== want.accepted   ||
                        o_result.is_full    !== want.is_full    ||
                        o_result.is_empty   !== want.is_empty   ||
                        o_result.fill_level !== want.fill_level) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: result mismatch exp %p got %p",
                                     $realtime, want, o_result);
                    end
                end
            end
            if (push && !full) begin
                status_due.push_back(apply_queue_op(i_item));
                beats_taken++;
            end
        end
    end

    initial begin
        int q;
        for (int k = 0; k < QCOUNT; k++) begin
            wr_ptr[k] = 0;
            rd_ptr[k] = 0;
            q_full[k] = 1'b0;
        end

        // directed
        add_cmd(OP_PUSH,  0, 8'h00);
        add_cmd(OP_PUSH,  0, 8'hFF);
        add_cmd(OP_PUSH,  1, 8'hA5);
        add_cmd(OP_PUSH,  2, 8'h5A);
        add_cmd(OP_PUSH,  3, 8'h80);
        add_cmd(OP_QUERY, 0, 8'h3C);
        add_cmd(OP_POP,   0, 8'hFF);
        add_cmd(OP_POP,   0, 8'h00);
        add_cmd(OP_POP,   0, 8'h77);   // empty queue
        add_cmd(OP_CLEAR, 1, 8'hFF);   // drops a held byte
        add_cmd(OP_QUERY, 1, 8'h00);
        add_cmd(OP_POP,   1, 8'h11);
        add_cmd(OP_CLEAR, 0, 8'h22);
        add_cmd(OP_POP,   2, 8'h01);
        add_cmd(OP_POP,   3, 8'hFE);
        add_cmd(OP_QUERY, 3, 8'hC3);
        add_cmd(OP_PUSH,  1, 8'h01);
        add_cmd(OP_PUSH,  1, 8'h7F);
        add_cmd(OP_QUERY, 2, 8'h55);
        add_cmd(OP_POP,   1, 8'hAA);

        // drive every queue past full and back down
        for (int k = 0; k < QCOUNT; k++) begin
            repeat (QDEPTH + 1) add_cmd(OP_PUSH, k, $urandom_range(0, 255));
            add_cmd(OP_QUERY, k, $urandom_range(0, 255));
            repeat (QDEPTH + 1) add_cmd(OP_POP, k, $urandom_range(0, 255));
        end

        while (cmd_backlog.size() < RAND_ITEMS) begin
            q = $urandom_range(0, QCOUNT-1);
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 20)) add_cmd(OP_PUSH, q, $urandom_range(0, 255));
                1: repeat ($urandom_range(1, 20)) add_cmd(OP_POP, q, $urandom_range(0, 255));
                default: repeat ($urandom_range(4, 16)) add_mixed(q);
            endcase
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || status_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && status_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
